>>> hw/rtl/lfia_pkg.sv
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared types, constants and helpers for the lowest-free index allocator:
// map geometry, command codes, channel payloads, controller/datapath links.
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int WORD_W    = 64;
    localparam int ROWS      = POOL_SIZE / WORD_W;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int HANDLE_W  = ROW_W + BIT_W;
    localparam int HW_W      = HANDLE_W + 1;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [BIT_W-1:0]    bitpos_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [HW_W-1:0]     hw_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        handle_t          handle;
    } in_t;

    typedef struct packed {
        handle_t granted;
        logic    ok;
        logic    in_use;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic save_res;
        logic alloc_step;
        logic release_set;
        logic trim_step;
        logic emit;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             exhausted;
        logic             in_range;
        logic             is_top;
        logic             scan_hit;
        logic             scan_last;
        logic             trim_hit;
        hw_t              high_water;
    } stat_t;

    // Position of the lowest set bit (0 when none is set)
    function automatic bitpos_t lowest_one(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = bitpos_t'(i);
            end
        end
        return pos;
    endfunction

    // Position of the highest set bit (0 when none is set)
    function automatic bitpos_t highest_one(input word_t w);
        bitpos_t pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                pos = bitpos_t'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> hw/rtl/lfia_ctrl.sv
// ----------------------------------------------------------------------------
// lfia_ctrl
// Sequencer for the allocator: takes one beat, steps the datapath through
// decode, map scan or top trim, then loads the output register.
// ----------------------------------------------------------------------------
module lfia_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  lfia_pkg::stat_t stat,
    output lfia_pkg::ctrl_t ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_TRIM,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    lfia_pkg::CMD_ALLOC:
                    begin
                        if (stat.exhausted)
                        begin
                            ctrl.save_res = 1'b1;
                            state_next    = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_ALLOC;
                        end
                    end
                    lfia_pkg::CMD_RELEASE:
                    begin
                        ctrl.save_res = 1'b1;
                        if (stat.in_range && stat.is_top)
                        begin
                            state_next = S_TRIM;
                        end
                        else
                        begin
                            ctrl.release_set = stat.in_range;
                            state_next       = S_FINISH;
                        end
                    end
                    default:
                    begin
                        ctrl.save_res = 1'b1;
                        state_next    = S_FINISH;
                    end
                endcase
            end
            S_ALLOC:
            begin
                ctrl.alloc_step = 1'b1;
                if (stat.scan_hit || stat.scan_last)
                begin
                    ctrl.save_res = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_TRIM:
            begin
                ctrl.trim_step = 1'b1;
                if (stat.trim_hit)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/lfia_datapath.sv
// ----------------------------------------------------------------------------
// lfia_datapath
// Free map (rows of 64 flags), high-water mark, limit register, row pointer,
// per-row lowest-free and top-run search, result and output registers.
// ----------------------------------------------------------------------------
module lfia_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfia_pkg::in_t             in_data,
    input  logic                      cfg_wen,
    input  lfia_pkg::hw_t             cfg_wdata,
    input  lfia_pkg::ctrl_t           ctrl,
    output lfia_pkg::stat_t           stat,
    output lfia_pkg::out_t            out_data
);

    lfia_pkg::word_t              map_reg [lfia_pkg::ROWS];
    lfia_pkg::hw_t                hw_reg;
    lfia_pkg::hw_t                hw_next;
    lfia_pkg::hw_t                limit_reg;
    lfia_pkg::row_t               ptr_reg;
    logic                         top_all_reg;
    logic [lfia_pkg::CMD_W-1:0]   cmd_reg;
    lfia_pkg::handle_t            handle_reg;
    lfia_pkg::out_t               res_reg;
    lfia_pkg::out_t               res_next;
    lfia_pkg::out_t               out_reg;

    lfia_pkg::word_t   word;
    lfia_pkg::word_t   below_mask;
    lfia_pkg::word_t   cand;
    lfia_pkg::word_t   keep_mask;
    lfia_pkg::bitpos_t low_pos;
    lfia_pkg::bitpos_t top_pos;
    lfia_pkg::bitpos_t h_pos;
    lfia_pkg::hw_t     hw_m1;
    lfia_pkg::hw_t     handle_ext;
    logic              exhausted;
    logic              in_range;
    logic              scan_hit;
    logic              scan_last;
    logic              trim_hit;

    assign word       = map_reg[ptr_reg];
    assign h_pos      = handle_reg[lfia_pkg::BIT_W-1:0];
    assign handle_ext = {1'b0, handle_reg};
    assign hw_m1      = hw_reg - lfia_pkg::hw_t'(1);

    assign exhausted = (hw_reg >= limit_reg)
                    || (hw_reg >= lfia_pkg::hw_t'(lfia_pkg::POOL_SIZE));
    assign in_range  = (handle_reg != '0) && (handle_ext < hw_reg);

    // allocate: lowest free handle in the current row
    assign scan_hit  = |word;
    assign low_pos   = lfia_pkg::lowest_one(word);
    assign scan_last = (ptr_reg == hw_m1[lfia_pkg::HANDLE_W-1:lfia_pkg::BIT_W]);

    // trim: highest allocated handle below the top in the current row;
    // handle 0 always reads as allocated, so row 0 always stops the walk
    assign below_mask = top_all_reg ? '1
                      : ((lfia_pkg::word_t'(1) << h_pos) - lfia_pkg::word_t'(1));
    assign cand       = ~word & below_mask;
    assign trim_hit   = |cand;
    assign top_pos    = lfia_pkg::highest_one(cand);
    assign keep_mask  = (lfia_pkg::word_t'(2) << top_pos) - lfia_pkg::word_t'(1);

    always_comb
    begin
        stat            = '0;
        stat.cmd        = cmd_reg;
        stat.exhausted  = exhausted;
        stat.in_range   = in_range;
        stat.is_top     = (handle_ext == hw_m1);
        stat.scan_hit   = scan_hit;
        stat.scan_last  = scan_last;
        stat.trim_hit   = trim_hit;
        stat.high_water = hw_reg;
    end

    always_comb
    begin
        res_next = '0;
        unique case (cmd_reg)
            lfia_pkg::CMD_ALLOC:
            begin
                if (!exhausted)
                begin
                    res_next.ok      = 1'b1;
                    res_next.granted = scan_hit ? {ptr_reg, low_pos}
                                                : hw_reg[lfia_pkg::HANDLE_W-1:0];
                end
            end
            lfia_pkg::CMD_RELEASE:
            begin
                res_next.ok = in_range;
            end
            lfia_pkg::CMD_QUERY:
            begin
                res_next.in_use = in_range && !word[h_pos];
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.alloc_step && !scan_hit && scan_last)
        begin
            hw_next = hw_reg + lfia_pkg::hw_t'(1);
        end
        else if (ctrl.trim_step && trim_hit)
        begin
            hw_next = {1'b0, ptr_reg, top_pos} + lfia_pkg::hw_t'(1);
        end
        else
        begin
            hw_next = hw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < lfia_pkg::ROWS; r++)
            begin
                map_reg[r] <= '0;
            end
        end
        else
        begin
            if (ctrl.alloc_step && scan_hit)
            begin
                map_reg[ptr_reg] <= word & ~(lfia_pkg::word_t'(1) << low_pos);
            end
            else if (ctrl.release_set)
            begin
                map_reg[ptr_reg] <= word | (lfia_pkg::word_t'(1) << h_pos);
            end
            else if (ctrl.trim_step)
            begin
                // drop every free flag above the allocated handle
                map_reg[ptr_reg] <= trim_hit ? (word & keep_mask) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg      <= lfia_pkg::hw_t'(1);
            limit_reg   <= lfia_pkg::hw_t'(lfia_pkg::POOL_SIZE);
            ptr_reg     <= '0;
            top_all_reg <= 1'b0;
            cmd_reg     <= lfia_pkg::CMD_ALLOC;
        end
        else
        begin
            hw_reg <= hw_next;
            if (cfg_wen)
            begin
                limit_reg <= cfg_wdata;
            end
            if (ctrl.capture)
            begin
                cmd_reg     <= in_data.command;
                ptr_reg     <= (in_data.command == lfia_pkg::CMD_ALLOC) ? '0
                             : in_data.handle[lfia_pkg::HANDLE_W-1:lfia_pkg::BIT_W];
                top_all_reg <= 1'b0;
            end
            else if (ctrl.alloc_step && !scan_hit)
            begin
                ptr_reg <= ptr_reg + lfia_pkg::row_t'(1);
            end
            else if (ctrl.trim_step && !trim_hit)
            begin
                ptr_reg     <= ptr_reg - lfia_pkg::row_t'(1);
                top_all_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            handle_reg <= in_data.handle;
        end
        if (ctrl.save_res)
        begin
            res_reg <= res_next;
        end
        if (ctrl.emit)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_data = out_reg;

endmodule

>>> hw/rtl/lowest_free_index_allocator_top.sv
// ----------------------------------------------------------------------------
// lowest_free_index_allocator_top
// Hands out handles from 1 upward: lowest released handle first, else the
// high-water mark. Release trims the free run at the top; query reports use.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   in       | in_valid / in_ready  | in_data  : command, handle
//   out      | out_valid / out_ready| out_data : granted, ok, in_use
//   cfg      | cfg_wen              | cfg_wdata: handle limit, exclusive
//
// One item at a time: the next beat is taken only after the result is loaded.
// Release, query and an exhausted allocate go from decode straight to the
// result; an allocate scan or a release trim visits 64-handle map rows (1 to
// 16 rows) with a one-row-per-cycle map search.
// Reset clears the map and sets the mark to 1 and the limit to 1024.
// A stalled output register holds its beat; the next beat is taken meanwhile.
// ----------------------------------------------------------------------------
module lowest_free_index_allocator_top
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lfia_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output lfia_pkg::out_t out_data,
    input  logic           cfg_wen,
    input  lfia_pkg::hw_t  cfg_wdata
);

    lfia_pkg::ctrl_t ctrl;
    lfia_pkg::stat_t stat;

    lfia_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lfia_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    a_mark_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        stat.high_water != '0
        && stat.high_water <= lfia_pkg::hw_t'(lfia_pkg::POOL_SIZE))
        else $error("high-water mark out of range");

    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.granted != '0 |-> out_data.ok && !out_data.in_use)
        else $error("grant without ok");

    a_query_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.in_use |-> !out_data.ok)
        else $error("in_use on a non-query result");
`endif

endmodule
